// ----- hw/rtl/rvis_pkg.sv -----
// Package for the RV64IM instruction step block: beat types, codes, helpers.
// No dependencies; used by every module in hw/rtl except rvis_ram.
package rvis_pkg;

  typedef struct packed {
    logic        mode;
    logic [31:0] instr_word;
    logic        fetch_ok;
    logic [63:0] load_data;
    logic        access_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [63:0] pc_out;
    logic [63:0] mem_address;
    logic [1:0]  mem_size;
    logic        mem_write;
    logic [63:0] store_data;
    logic [2:0]  exit_reason;
    logic [4:0]  fault_register;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  f3;
    logic        word;
    logic [63:0] a;
    logic [63:0] b;
  } md_req_t;

  typedef struct packed {
    logic        en;
    logic [63:0] data;
  } cfg_wr_t;

  localparam logic [1:0] KIND_RETIRE = 2'd0;
  localparam logic [1:0] KIND_REQ    = 2'd1;
  localparam logic [1:0] KIND_EXIT   = 2'd2;

  localparam logic [2:0] EXIT_UNALIGNED = 3'd0;
  localparam logic [2:0] EXIT_FETCH     = 3'd1;
  localparam logic [2:0] EXIT_READ      = 3'd2;
  localparam logic [2:0] EXIT_WRITE     = 3'd3;
  localparam logic [2:0] EXIT_ECALL     = 3'd4;
  localparam logic [2:0] EXIT_EBREAK    = 3'd5;
  localparam logic [2:0] EXIT_UNDEF     = 3'd6;

  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_IMM    = 7'h13;
  localparam logic [6:0] OPC_IMM32  = 7'h1b;
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OP32   = 7'h3b;
  localparam logic [6:0] OPC_FENCE  = 7'h0f;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [31:0] WORD_ECALL  = 32'h0000_0073;
  localparam logic [31:0] WORD_EBREAK = 32'h0010_0073;

  localparam logic [2:0] F3_MUL  = 3'd0;
  localparam logic [2:0] F3_DIV  = 3'd4;
  localparam logic [2:0] F3_DIVU = 3'd5;
  localparam logic [2:0] F3_REM  = 3'd6;
  localparam logic [2:0] F3_REMU = 3'd7;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [6:0] F7_MD   = 7'h01;

  localparam int XLEN    = 64;
  localparam int NREGS   = 32;
  localparam int QDEPTH  = 2;

  function automatic logic [63:0] sext32(input logic [63:0] x);
    sext32 = {{32{x[31]}}, x[31:0]};
  endfunction

endpackage

// ----- hw/rtl/rvis_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rvis_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- hw/rtl/rvis_front.sv -----
// Front end: accepts input beats into a short queue toward the execute side.
// Depends on rvis_pkg.
module rvis_front
  import rvis_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_item_t in_item,
  output logic     hd_valid,
  output in_item_t hd_item,
  input  logic     pop
);
  in_item_t   q_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_stall = (cnt_r == 2'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign hd_valid = (cnt_r != 2'd0);
  assign hd_item  = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= in_item;
    end
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end
endmodule

// ----- hw/rtl/rvis_muldiv.sv -----
// Iterative multiply / divide unit, one bit per cycle.
// Depends on rvis_pkg.
module rvis_muldiv
  import rvis_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  md_req_t     req,
  output logic        done,
  output logic [63:0] result
);
  logic        busy_r, done_r;
  logic [5:0]  cnt_r;
  logic [63:0] acc_r, x_r, y_r;
  logic        na_r, nb_r, bz_r, word_r;
  logic [2:0]  f3_r;
  logic [63:0] oa, ob, ua, ub, acc_nxt, x_nxt, y_nxt, q, r, res;
  logic [64:0] rs;
  logic        sgn, na, nb;

  always_comb begin
    sgn = (req.f3 == F3_DIV) || (req.f3 == F3_REM);
    if (req.word) begin
      oa = sgn ? sext32(req.a) : {32'd0, req.a[31:0]};
      ob = sgn ? sext32(req.b) : {32'd0, req.b[31:0]};
    end else begin
      oa = req.a;
      ob = req.b;
    end
    na = sgn && oa[63];
    nb = sgn && ob[63];
    ua = na ? (64'd0 - oa) : oa;
    ub = nb ? (64'd0 - ob) : ob;

    rs = {acc_r, x_r[63]};
    if (f3_r == F3_MUL) begin
      acc_nxt = acc_r + (x_r[0] ? y_r : 64'd0);
      x_nxt   = {1'b0, x_r[63:1]};
      y_nxt   = {y_r[62:0], 1'b0};
    end else begin
      y_nxt = y_r;
      if (rs >= {1'b0, y_r}) begin
        acc_nxt = 64'(rs - {1'b0, y_r});
        x_nxt   = {x_r[62:0], 1'b1};
      end else begin
        acc_nxt = rs[63:0];
        x_nxt   = {x_r[62:0], 1'b0};
      end
    end

    q = bz_r ? {64{1'b1}} : ((na_r ^ nb_r) ? (64'd0 - x_r) : x_r);
    r = na_r ? (64'd0 - acc_r) : acc_r;
    case (f3_r)
      F3_MUL:           res = acc_r;
      F3_DIV, F3_DIVU:  res = q;
      default:          res = r;
    endcase
    result = word_r ? sext32(res) : res;
  end

  assign done = done_r;

  always_ff @(posedge clk) begin
    if (start) begin
      f3_r   <= req.f3;
      word_r <= req.word;
      na_r   <= na;
      nb_r   <= nb;
      bz_r   <= (ob == 64'd0);
      acc_r  <= 64'd0;
      if (req.f3 == F3_MUL) begin
        x_r <= oa;
        y_r <= ob;
      end else begin
        x_r <= ua;
        y_r <= ub;
      end
    end else if (busy_r) begin
      acc_r <= acc_nxt;
      x_r   <= x_nxt;
      y_r   <= y_nxt;
    end
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '1;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 6'd1;
      if (cnt_r == 6'd0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end
endmodule

// ----- hw/rtl/rvis_back.sv -----
// Execute side: register file, pc, pending access record, result register.
// Depends on rvis_pkg, rvis_ram, rvis_muldiv.
module rvis_back
  import rvis_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        hd_valid,
  input  in_item_t    hd_item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  cfg_wr_t     cfg_wr,
  output logic [63:0] start_pc
);
  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EX   = 3'b010,
    S_MD   = 3'b100
  } state_t;

  state_t      state_r, state_nxt;
  logic [63:0] pc_r, pc_nxt, start_pc_r;
  logic        pend_r, pend_nxt, pend_st_r, pend_st_nxt;
  logic [4:0]  pend_reg_r, pend_reg_nxt;
  logic [2:0]  pend_kind_r, pend_kind_nxt;
  logic [63:0] pend_addr_r, pend_addr_nxt;
  logic        out_valid_r, out_valid_nxt;
  out_item_t   out_item_r, out_item_nxt;
  logic [NREGS-1:0] rvld_r;
  logic        vld_a_r, vld_b_r;
  logic [63:0] ra, rb, a, b;
  logic        we;
  logic [4:0]  waddr;
  logic [63:0] wdata;
  logic        md_start, md_done;
  md_req_t     md_req;
  logic [63:0] md_res;

  logic [31:0] w;
  logic [6:0]  opc, f7;
  logic [4:0]  rd, rs1, rs2;
  logic [2:0]  f3;
  logic [63:0] immi, imms, immb, immj, immu, nxt4, ld;
  logic        out_free, emit, undef, wr, is_md, taken;
  logic [63:0] wval, next;
  logic [5:0]  sh;

  assign w   = hd_item.instr_word;
  assign opc = w[6:0];
  assign rd  = w[11:7];
  assign f3  = w[14:12];
  assign rs1 = w[19:15];
  assign rs2 = w[24:20];
  assign f7  = w[31:25];
  assign sh  = w[25:20];
  assign immi = {{52{w[31]}}, w[31:20]};
  assign imms = {{52{w[31]}}, w[31:25], w[11:7]};
  assign immb = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
  assign immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
  assign immu = {{32{w[31]}}, w[31:12], 12'd0};

  rvis_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_a (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(rs1), .rdata(ra)
  );
  rvis_ram #(.WIDTH(XLEN), .DEPTH(NREGS)) u_rf_b (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(rs2), .rdata(rb)
  );

  assign a = vld_a_r ? ra : 64'd0;
  assign b = vld_b_r ? rb : 64'd0;

  assign md_req = '{f3: f3, word: (opc == OPC_OP32), a: a, b: b};

  rvis_muldiv u_md (
    .clk(clk), .rst_n(rst_n), .start(md_start), .req(md_req),
    .done(md_done), .result(md_res)
  );

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign start_pc  = start_pc_r;
  assign nxt4      = pc_r + 64'd4;

  always_comb begin
    case (pend_kind_r)
      3'd0:    ld = {{56{hd_item.load_data[7]}}, hd_item.load_data[7:0]};
      3'd1:    ld = {{48{hd_item.load_data[15]}}, hd_item.load_data[15:0]};
      3'd2:    ld = sext32(hd_item.load_data);
      3'd4:    ld = {56'd0, hd_item.load_data[7:0]};
      3'd5:    ld = {48'd0, hd_item.load_data[15:0]};
      3'd6:    ld = {32'd0, hd_item.load_data[31:0]};
      default: ld = hd_item.load_data;
    endcase
  end

  // instruction decode and simple execute
  always_comb begin
    undef = 1'b0;
    wr    = 1'b0;
    wval  = 64'd0;
    next  = nxt4;
    is_md = 1'b0;
    taken = 1'b0;
    unique case (opc)
      OPC_LUI: begin
        wr = 1'b1; wval = immu;
      end
      OPC_AUIPC: begin
        wr = 1'b1; wval = pc_r + immu;
      end
      OPC_JAL: begin
        wr = 1'b1; wval = nxt4; next = pc_r + immj;
      end
      OPC_JALR: begin
        if (f3 != 3'd0) undef = 1'b1;
        else begin
          wr = 1'b1; wval = nxt4; next = (a + immi) & ~64'd1;
        end
      end
      OPC_BRANCH: begin
        case (f3)
          3'd0: taken = (a == b);
          3'd1: taken = (a != b);
          3'd4: taken = ($signed(a) < $signed(b));
          3'd5: taken = !($signed(a) < $signed(b));
          3'd6: taken = (a < b);
          3'd7: taken = (a >= b);
          default: undef = 1'b1;
        endcase
        if (taken) next = pc_r + immb;
      end
      OPC_LOAD:  undef = (f3 == 3'd7);
      OPC_STORE: undef = f3[2];
      OPC_IMM: begin
        wr = 1'b1;
        case (f3)
          3'd0: wval = a + immi;
          3'd1: begin
            wval = a << sh; undef = (w[31:26] != 6'd0);
          end
          3'd2: wval = {63'd0, $signed(a) < $signed(immi)};
          3'd3: wval = {63'd0, a < immi};
          3'd4: wval = a ^ immi;
          3'd5: begin
            if (w[31:26] == 6'd0) wval = a >> sh;
            else if (w[31:26] == 6'h10) wval = 64'($signed(a) >>> sh);
            else undef = 1'b1;
          end
          3'd6: wval = a | immi;
          default: wval = a & immi;
        endcase
      end
      OPC_IMM32: begin
        wr = 1'b1;
        if (f3 == 3'd0) wval = sext32(a + immi);
        else if (f3 == 3'd1 && f7 == F7_BASE) wval = sext32({32'd0, a[31:0] << rs2});
        else if (f3 == 3'd5 && f7 == F7_BASE) wval = sext32({32'd0, a[31:0] >> rs2});
        else if (f3 == 3'd5 && f7 == F7_ALT)
          wval = sext32({32'd0, 32'($signed(a[31:0]) >>> rs2)});
        else undef = 1'b1;
      end
      OPC_OP: begin
        wr = 1'b1;
        if (f7 == F7_BASE) begin
          case (f3)
            3'd0: wval = a + b;
            3'd1: wval = a << b[5:0];
            3'd2: wval = {63'd0, $signed(a) < $signed(b)};
            3'd3: wval = {63'd0, a < b};
            3'd4: wval = a ^ b;
            3'd5: wval = a >> b[5:0];
            3'd6: wval = a | b;
            default: wval = a & b;
          endcase
        end else if (f7 == F7_ALT && f3 == 3'd0) wval = a - b;
        else if (f7 == F7_ALT && f3 == 3'd5) wval = 64'($signed(a) >>> b[5:0]);
        else if (f7 == F7_MD && (f3 == F3_MUL || f3[2])) is_md = 1'b1;
        else undef = 1'b1;
      end
      OPC_OP32: begin
        wr = 1'b1;
        if (f7 == F7_BASE && f3 == 3'd0) wval = sext32(a + b);
        else if (f7 == F7_BASE && f3 == 3'd1) wval = sext32({32'd0, a[31:0] << b[4:0]});
        else if (f7 == F7_BASE && f3 == 3'd5) wval = sext32({32'd0, a[31:0] >> b[4:0]});
        else if (f7 == F7_ALT && f3 == 3'd0) wval = sext32(a - b);
        else if (f7 == F7_ALT && f3 == 3'd5)
          wval = sext32({32'd0, 32'($signed(a[31:0]) >>> b[4:0])});
        else if (f7 == F7_MD && (f3 == F3_MUL || f3[2])) is_md = 1'b1;
        else undef = 1'b1;
      end
      OPC_FENCE:  undef = (f3 != 3'd0);
      OPC_SYSTEM: undef = (w != WORD_ECALL) && (w != WORD_EBREAK);
      default:    undef = 1'b1;
    endcase
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    pend_nxt      = pend_r;
    pend_st_nxt   = pend_st_r;
    pend_reg_nxt  = pend_reg_r;
    pend_kind_nxt = pend_kind_r;
    pend_addr_nxt = pend_addr_r;
    pop      = 1'b0;
    emit     = 1'b0;
    md_start = 1'b0;
    we       = 1'b0;
    waddr    = rd;
    wdata    = wval;
    out_item_nxt = '0;
    out_item_nxt.pc_out = pc_r;
    unique case (state_r)
      S_IDLE: begin
        if (hd_valid) state_nxt = S_EX;
      end
      S_EX: begin
        if (hd_item.mode) begin
          if (!pend_r) begin
            pop = 1'b1; state_nxt = S_IDLE;
          end else if (out_free) begin
            pop = 1'b1; emit = 1'b1; state_nxt = S_IDLE; pend_nxt = 1'b0;
            if (!hd_item.access_ok) begin
              out_item_nxt.kind           = KIND_EXIT;
              out_item_nxt.mem_address    = pend_addr_r;
              out_item_nxt.exit_reason    = pend_st_r ? EXIT_WRITE : EXIT_READ;
              out_item_nxt.fault_register = pend_reg_r;
            end else begin
              we    = !pend_st_r && (pend_reg_r != 5'd0);
              waddr = pend_reg_r;
              wdata = ld;
              pc_nxt = nxt4;
              out_item_nxt.kind   = KIND_RETIRE;
              out_item_nxt.pc_out = nxt4;
            end
          end
        end else if (pend_r) begin
          pop = 1'b1; state_nxt = S_IDLE;
        end else if (pc_r[1:0] != 2'd0 || !hd_item.fetch_ok) begin
          if (out_free) begin
            pop = 1'b1; emit = 1'b1; state_nxt = S_IDLE;
            out_item_nxt.kind        = KIND_EXIT;
            out_item_nxt.mem_address = pc_r;
            out_item_nxt.exit_reason = (pc_r[1:0] != 2'd0) ? EXIT_UNALIGNED : EXIT_FETCH;
          end
        end else if (undef) begin
          if (out_free) begin
            pop = 1'b1; emit = 1'b1; state_nxt = S_IDLE;
            out_item_nxt.kind        = KIND_EXIT;
            out_item_nxt.exit_reason = EXIT_UNDEF;
          end
        end else if (is_md) begin
          md_start  = 1'b1;
          state_nxt = S_MD;
        end else if (opc == OPC_SYSTEM) begin
          if (out_free) begin
            pop = 1'b1; emit = 1'b1; state_nxt = S_IDLE;
            out_item_nxt.kind        = KIND_EXIT;
            out_item_nxt.exit_reason = (w == WORD_ECALL) ? EXIT_ECALL : EXIT_EBREAK;
          end
        end else if (opc == OPC_LOAD || opc == OPC_STORE) begin
          if (out_free) begin
            pop = 1'b1; emit = 1'b1; state_nxt = S_IDLE;
            pend_nxt      = 1'b1;
            pend_st_nxt   = (opc == OPC_STORE);
            pend_reg_nxt  = (opc == OPC_STORE) ? rs2 : rd;
            pend_kind_nxt = f3;
            pend_addr_nxt = a + ((opc == OPC_STORE) ? imms : immi);
            out_item_nxt.kind        = KIND_REQ;
            out_item_nxt.mem_address = pend_addr_nxt;
            out_item_nxt.mem_size    = f3[1:0];
            out_item_nxt.mem_write   = (opc == OPC_STORE);
            out_item_nxt.store_data  = (opc == OPC_STORE) ? b : 64'd0;
          end
        end else if (out_free) begin
          pop = 1'b1; emit = 1'b1; state_nxt = S_IDLE;
          we     = wr && (rd != 5'd0);
          pc_nxt = next;
          out_item_nxt.kind   = KIND_RETIRE;
          out_item_nxt.pc_out = next;
        end
      end
      S_MD: begin
        if (md_done && out_free) begin
          pop = 1'b1; emit = 1'b1; state_nxt = S_IDLE;
          we     = (rd != 5'd0);
          wdata  = md_res;
          pc_nxt = nxt4;
          out_item_nxt.kind   = KIND_RETIRE;
          out_item_nxt.pc_out = nxt4;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    vld_a_r <= rvld_r[rs1];
    vld_b_r <= rvld_r[rs2];
    if (emit) out_item_r <= out_item_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pc_r        <= 64'd0;
      start_pc_r  <= 64'd0;
      pend_r      <= 1'b0;
      pend_reg_r  <= 5'd0;
      pend_kind_r <= 3'd0;
      pend_addr_r <= 64'd0;
      pend_st_r   <= 1'b0;
      out_valid_r <= 1'b0;
      rvld_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      pend_reg_r  <= pend_reg_nxt;
      pend_kind_r <= pend_kind_nxt;
      pend_addr_r <= pend_addr_nxt;
      pend_st_r   <= pend_st_nxt;
      out_valid_r <= out_valid_nxt;
      if (we) rvld_r[waddr] <= 1'b1;
      if (cfg_wr.en) begin
        start_pc_r <= cfg_wr.data;
        pc_r       <= cfg_wr.data;
      end else begin
        pc_r <= pc_nxt;
      end
    end
  end
endmodule

// ----- hw/rtl/rv64im_instruction_step.sv -----
// Top level of the RV64IM instruction step block.
// Depends on rvis_pkg, rvis_front, rvis_back.
//
// One RV64IM integer core driven one beat at a time: a fetch beat (mode 0)
// carries the word at the current pc, a response beat (mode 1) completes the
// load or store that the previous request started. Each accepted beat gives at
// most one result beat (retire, memory request or exit). Beats enter a
// two-deep queue; the execute side reads the register file (registered RAM)
// in the idle state and executes in the state after it; MUL, DIV, DIVU, REM,
// REMU and their word forms go through a bit-serial unit. The start_pc
// register sits at address 0 of the APB port; writing it also loads the pc.
module rv64im_instruction_step
  import rvis_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_item,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_item,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);
  logic        hd_valid, pop;
  in_item_t    hd_item;
  cfg_wr_t     cfg_wr;
  logic [63:0] start_pc;

  assign cfg_pready  = 1'b1;
  assign cfg_wr.en   = cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr == 4'd0);
  assign cfg_wr.data = cfg_pwdata;
  assign cfg_prdata  = (cfg_paddr == 4'd0) ? start_pc : 64'd0;

  rvis_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .hd_valid(hd_valid), .hd_item(hd_item), .pop(pop)
  );

  rvis_back u_back (
    .clk(clk), .rst_n(rst_n), .hd_valid(hd_valid), .hd_item(hd_item), .pop(pop),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_wr(cfg_wr), .start_pc(start_pc)
  );

  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.kind == KIND_RETIRE || out_item.kind == KIND_REQ ||
                   out_item.kind == KIND_EXIT))
    else $error("bad result kind");

  a_retire_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_RETIRE |->
      out_item.exit_reason == 3'd0 && !out_item.mem_write && out_item.mem_address == 64'd0)
    else $error("retire carries request or exit fields");

  a_load_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_REQ && !out_item.mem_write |->
      out_item.store_data == 64'd0)
    else $error("load request carries store data");
endmodule

// ----- bench/tb_rv64im_instruction_step.sv -----
// Self-checking bench for rv64im_instruction_step: random and directed RV64IM beats
// checked against an in-bench instruction predictor. Depends on rvis_pkg and the RTL.
`timescale 1ns / 1ps
module tb_rv64im_instruction_step;
  import rvis_pkg::*;

  localparam int LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_stall;
  out_item_t   out_item;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [63:0] cfg_pwdata;
  logic [63:0] cfg_prdata;
  logic        cfg_pready;

  rv64im_instruction_step i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  // predictor state
  logic [63:0] regs [32];
  logic [63:0] pc;
  logic        pend;
  logic [4:0]  pend_reg;
  logic [2:0]  pend_kind;
  logic        pend_store;
  logic [63:0] pend_addr;

  in_item_t  beat_q [$];
  out_item_t result_q [$];
  int        errors;
  int        n_beats;
  int        n_results;
  int        idle_cnt;
  int        send_pct;
  int        stall_pct;
  int        hold_cnt;
  bit        hold_req;
  bit        done;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic logic [63:0] sx(input logic [63:0] x, input int bits);
    logic [63:0] m;
    m = {64{1'b1}} << bits;
    sx = x[bits-1] ? (x | m) : (x & ~m);
  endfunction

  function automatic logic [63:0] sdiv(input logic [63:0] a, input logic [63:0] b,
                                       input bit rem);
    logic [63:0] ua, ub, q, r;
    if (b == 0) return rem ? a : '1;
    ua = a[63] ? -a : a;
    ub = b[63] ? -b : b;
    q = ua / ub;
    r = ua % ub;
    if (rem) return a[63] ? -r : r;
    return (a[63] != b[63]) ? -q : q;
  endfunction

  function automatic logic [63:0] udiv(input logic [63:0] a, input logic [63:0] b,
                                       input bit rem);
    if (b == 0) return rem ? a : '1;
    return rem ? a % b : a / b;
  endfunction

  function automatic logic [63:0] sra(input logic [63:0] a, input int s);
    return $signed(a) >>> s;
  endfunction

  function automatic out_item_t mk(input logic [1:0] k, input logic [63:0] p,
                                   input logic [63:0] ad, input logic [2:0] rsn);
    out_item_t o;
    o = '0;
    o.kind = k;
    o.pc_out = p;
    o.mem_address = ad;
    o.exit_reason = rsn;
    return o;
  endfunction

  function automatic void wr_reg(input logic [4:0] r, input logic [63:0] v);
    if (r != 0) regs[r] = v;
  endfunction

  task automatic reset_core(input logic [63:0] spc);
    foreach (regs[i]) regs[i] = '0;
    pc = spc;
    pend = 0;
    pend_reg = 0;
    pend_kind = 0;
    pend_store = 0;
    pend_addr = 0;
  endtask

  // returns 0 when the beat yields no result
  function automatic bit step_core(input in_item_t it, output out_item_t o);
    logic [31:0] w;
    logic [6:0]  op, f7;
    logic [4:0]  rd, rs1, rs2;
    logic [2:0]  f3;
    logic [5:0]  f6;
    logic [63:0] a, b, immi, nxt, v, la, lb, r;
    bit          undef, t;
    int          sh;
    o = '0;
    if (it.mode) begin
      if (!pend) return 0;
      pend = 0;
      if (!it.access_ok) begin
        o = mk(KIND_EXIT, pc, pend_addr, pend_store ? EXIT_WRITE : EXIT_READ);
        o.fault_register = pend_reg;
        return 1;
      end
      if (!pend_store) begin
        case (pend_kind)
          0: v = sx(it.load_data, 8);
          1: v = sx(it.load_data, 16);
          2: v = sx(it.load_data, 32);
          4: v = it.load_data & 64'hff;
          5: v = it.load_data & 64'hffff;
          6: v = it.load_data & 64'hffff_ffff;
          default: v = it.load_data;
        endcase
        wr_reg(pend_reg, v);
      end
      pc = pc + 4;
      o = mk(KIND_RETIRE, pc, 0, 0);
      return 1;
    end
    if (pend) return 0;
    if (pc[1:0] != 0) begin
      o = mk(KIND_EXIT, pc, pc, EXIT_UNALIGNED);
      return 1;
    end
    if (!it.fetch_ok) begin
      o = mk(KIND_EXIT, pc, pc, EXIT_FETCH);
      return 1;
    end
    w = it.instr_word;
    op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; rs1 = w[19:15]; rs2 = w[24:20];
    f7 = w[31:25]; f6 = w[31:26];
    a = regs[rs1]; b = regs[rs2];
    immi = sx(w[31:20], 12);
    nxt = pc + 4;
    undef = 0;
    case (op)
      OPC_LUI: wr_reg(rd, sx({w[31:12], 12'h0}, 32));
      OPC_AUIPC: wr_reg(rd, pc + sx({w[31:12], 12'h0}, 32));
      OPC_JAL: begin
        wr_reg(rd, nxt);
        nxt = pc + sx({w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
      end
      OPC_JALR: begin
        if (f3 != 0) undef = 1;
        else begin
          wr_reg(rd, nxt);
          nxt = (a + immi) & ~64'd1;
        end
      end
      OPC_BRANCH: begin
        t = 0;
        case (f3)
          0: t = a == b;
          1: t = a != b;
          4: t = $signed(a) < $signed(b);
          5: t = !($signed(a) < $signed(b));
          6: t = a < b;
          7: t = a >= b;
          default: undef = 1;
        endcase
        if (t) nxt = pc + sx({w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
      end
      OPC_LOAD: begin
        if (f3 == 7) undef = 1;
        else begin
          pend = 1; pend_store = 0; pend_reg = rd; pend_kind = f3;
          pend_addr = a + immi;
          o = mk(KIND_REQ, pc, pend_addr, 0);
          o.mem_size = f3[1:0];
          return 1;
        end
      end
      OPC_STORE: begin
        if (f3 > 3) undef = 1;
        else begin
          pend = 1; pend_store = 1; pend_reg = rs2; pend_kind = f3;
          pend_addr = a + sx({w[31:25], w[11:7]}, 12);
          o = mk(KIND_REQ, pc, pend_addr, 0);
          o.mem_size = f3[1:0];
          o.mem_write = 1;
          o.store_data = b;
          return 1;
        end
      end
      OPC_IMM: begin
        sh = w[25:20];
        case (f3)
          0: wr_reg(rd, a + immi);
          1: if (f6 == 0) wr_reg(rd, a << sh); else undef = 1;
          2: wr_reg(rd, ($signed(a) < $signed(immi)) ? 64'd1 : 64'd0);
          3: wr_reg(rd, (a < immi) ? 64'd1 : 64'd0);
          4: wr_reg(rd, a ^ immi);
          5: if (f6 == 0) wr_reg(rd, a >> sh);
             else if (f6 == 6'h10) wr_reg(rd, sra(a, sh));
             else undef = 1;
          6: wr_reg(rd, a | immi);
          default: wr_reg(rd, a & immi);
        endcase
      end
      OPC_IMM32: begin
        if (f3 == 0) wr_reg(rd, sx(a + immi, 32));
        else if (f3 == 1 && f7 == F7_BASE) wr_reg(rd, sx(a << rs2, 32));
        else if (f3 == 5 && f7 == F7_BASE) wr_reg(rd, sx((a & 64'hffff_ffff) >> rs2, 32));
        else if (f3 == 5 && f7 == F7_ALT) wr_reg(rd, sx(sra(sx(a, 32), rs2), 32));
        else undef = 1;
      end
      OPC_OP: begin
        if (f7 == F7_BASE) begin
          case (f3)
            0: r = a + b;
            1: r = a << b[5:0];
            2: r = ($signed(a) < $signed(b)) ? 64'd1 : 64'd0;
            3: r = (a < b) ? 64'd1 : 64'd0;
            4: r = a ^ b;
            5: r = a >> b[5:0];
            6: r = a | b;
            default: r = a & b;
          endcase
          wr_reg(rd, r);
        end else if (f7 == F7_ALT && f3 == 0) wr_reg(rd, a - b);
        else if (f7 == F7_ALT && f3 == 5) wr_reg(rd, sra(a, b[5:0]));
        else if (f7 == F7_MD) begin
          case (f3)
            F3_MUL: wr_reg(rd, a * b);
            F3_DIV: wr_reg(rd, sdiv(a, b, 0));
            F3_DIVU: wr_reg(rd, udiv(a, b, 0));
            F3_REM: wr_reg(rd, sdiv(a, b, 1));
            F3_REMU: wr_reg(rd, udiv(a, b, 1));
            default: undef = 1;
          endcase
        end else undef = 1;
      end
      OPC_OP32: begin
        la = a & 64'hffff_ffff;
        lb = b & 64'hffff_ffff;
        sh = b[4:0];
        if (f7 == F7_BASE && f3 == 0) wr_reg(rd, sx(la + lb, 32));
        else if (f7 == F7_BASE && f3 == 1) wr_reg(rd, sx(la << sh, 32));
        else if (f7 == F7_BASE && f3 == 5) wr_reg(rd, sx(la >> sh, 32));
        else if (f7 == F7_ALT && f3 == 0) wr_reg(rd, sx(la - lb, 32));
        else if (f7 == F7_ALT && f3 == 5) wr_reg(rd, sx(sra(sx(a, 32), sh), 32));
        else if (f7 == F7_MD && f3 == F3_MUL) wr_reg(rd, sx(la * lb, 32));
        else if (f7 == F7_MD && f3 == F3_DIV) wr_reg(rd, sx(sdiv(sx(a, 32), sx(b, 32), 0), 32));
        else if (f7 == F7_MD && f3 == F3_DIVU) wr_reg(rd, sx(udiv(la, lb, 0), 32));
        else if (f7 == F7_MD && f3 == F3_REM) wr_reg(rd, sx(sdiv(sx(a, 32), sx(b, 32), 1), 32));
        else if (f7 == F7_MD && f3 == F3_REMU) wr_reg(rd, sx(udiv(la, lb, 1), 32));
        else undef = 1;
      end
      OPC_FENCE: if (f3 != 0) undef = 1;
      OPC_SYSTEM: begin
        if (w == WORD_ECALL) begin
          o = mk(KIND_EXIT, pc, 0, EXIT_ECALL);
          return 1;
        end
        if (w == WORD_EBREAK) begin
          o = mk(KIND_EXIT, pc, 0, EXIT_EBREAK);
          return 1;
        end
        undef = 1;
      end
      default: undef = 1;
    endcase
    if (undef) begin
      o = mk(KIND_EXIT, pc, 0, EXIT_UNDEF);
      return 1;
    end
    pc = nxt;
    o = mk(KIND_RETIRE, nxt, 0, 0);
    return 1;
  endfunction

  // instruction builder
  function automatic logic [31:0] rand_word();
    logic [31:0] w;
    logic [6:0]  ops [13];
    logic [6:0]  f7s [3];
    int k;
    ops = '{OPC_LUI, OPC_AUIPC, OPC_JAL, OPC_JALR, OPC_BRANCH, OPC_LOAD, OPC_STORE,
            OPC_IMM, OPC_IMM32, OPC_OP, OPC_OP32, OPC_FENCE, OPC_SYSTEM};
    f7s = '{F7_BASE, F7_ALT, F7_MD};
    k = $urandom_range(0, 99);
    w = $urandom;
    if (k < 3) return w;
    if (k < 5) return ($urandom_range(0, 1)) ? WORD_ECALL : WORD_EBREAK;
    w[6:0] = ops[$urandom_range(0, 12)];
    if (w[6:0] == OPC_OP || w[6:0] == OPC_OP32) begin
      w[31:25] = f7s[$urandom_range(0, 2)];
      if (w[6:0] == OPC_OP && w[31:25] == F7_MD && $urandom_range(0, 3) == 0)
        w[14:12] = F3_MUL;
    end
    if (w[6:0] == OPC_IMM && $urandom_range(0, 1)) w[31:26] = $urandom_range(0, 1) ? 6'h10 : 6'h0;
    if (w[6:0] == OPC_IMM32 && $urandom_range(0, 1)) w[31:25] = f7s[$urandom_range(0, 1)];
    // keep control flow mostly aligned
    if (w[6:0] == OPC_JAL && $urandom_range(0, 7) != 0) w[21] = 0;
    if (w[6:0] == OPC_BRANCH && $urandom_range(0, 7) != 0) w[8] = 0;
    if (w[6:0] == OPC_JALR && $urandom_range(0, 3) != 0) begin
      w[14:12] = 0;
      w[21:20] = 0;
      w[19:15] = 0;
    end
    if ((w[6:0] == OPC_FENCE || w[6:0] == OPC_JALR) && $urandom_range(0, 3) != 0) w[14:12] = 0;
    return w;
  endfunction

  task automatic push_fetch(input logic [31:0] w, input bit ok);
    in_item_t it;
    it = '0;
    it.instr_word = w;
    it.fetch_ok = ok;
    it.load_data = {$urandom, $urandom};
    it.access_ok = 1'($urandom_range(0, 1));
    beat_q.push_back(it);
    // a memory op gets its response next, mostly
    if (ok && (w[6:0] == OPC_LOAD || w[6:0] == OPC_STORE) && $urandom_range(0, 9) != 0) begin
      it = '0;
      it.mode = 1;
      it.load_data = {$urandom, $urandom};
      it.access_ok = ($urandom_range(0, 9) != 0);
      it.instr_word = $urandom;
      it.fetch_ok = 1'($urandom_range(0, 1));
      beat_q.push_back(it);
    end
  endtask

  task automatic push_random(input int n);
    in_item_t it;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 49) == 0) begin
        it = '0;
        it.mode = 1;
        it.instr_word = $urandom;
        it.fetch_ok = 1'($urandom_range(0, 1));
        it.load_data = {$urandom, $urandom};
        it.access_ok = 1'($urandom_range(0, 1));
        beat_q.push_back(it);
      end else begin
        push_fetch(rand_word(), $urandom_range(0, 39) != 0);
      end
    end
  endtask

  task automatic cfg_write(input logic [63:0] v);
    @(posedge clk);
    cfg_psel <= 1; cfg_penable <= 0; cfg_pwrite <= 1; cfg_paddr <= 0; cfg_pwdata <= v;
    @(posedge clk);
    cfg_penable <= 1;
    @(posedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    pc = v;
  endtask

  task automatic wait_idle();
    while (beat_q.size() != 0 || in_valid || result_q.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst_n) begin
      in_valid <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        n_beats++;
        if (step_core(in_item, exp_r)) result_q.push_back(exp_r);
      end
      if (!in_valid || !in_stall) begin
        if (beat_q.size() != 0 && $urandom_range(0, 99) >= send_pct) begin
          in_item <= beat_q.pop_front();
          in_valid <= 1;
        end else begin
          in_valid <= 0;
        end
      end
    end
  end

  // receiver stall
  always @(posedge clk) begin
    if (hold_req && hold_cnt == 0) hold_cnt <= 300;
    else if (hold_cnt > 1) hold_cnt <= hold_cnt - 1;
    else if (hold_cnt == 1) hold_cnt <= 0;
    if (hold_cnt > 1 || (hold_req && hold_cnt == 0)) out_stall <= 1;
    else out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // monitor
  always @(posedge clk) begin
    out_item_t e;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (result_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_item);
        errors++;
      end else begin
        e = result_q.pop_front();
        if (out_item.kind !== e.kind || out_item.pc_out !== e.pc_out ||
            out_item.mem_address !== e.mem_address || out_item.mem_size !== e.mem_size ||
            out_item.mem_write !== e.mem_write || out_item.store_data !== e.store_data ||
            out_item.exit_reason !== e.exit_reason ||
            out_item.fault_register !== e.fault_register) begin
          $display("%0t: mismatch expected %p actual %p", $time, e, out_item);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || done || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt <= 0;
    else idle_cnt <= idle_cnt + 1;
    if (idle_cnt >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    errors = 0; n_beats = 0; n_results = 0; idle_cnt = 0; hold_cnt = 0;
    hold_req = 0; done = 0; send_pct = 0; stall_pct = 0;
    in_valid = 0; in_item = '0; out_stall = 0;
    cfg_psel = 0; cfg_penable = 0; cfg_pwrite = 0; cfg_paddr = 0; cfg_pwdata = 0;
    rst_n = 0;
    reset_core(0);
    repeat (4) @(posedge clk);
    rst_n <= 1;

    // directed: build operands, hit ops and exits
    push_fetch({20'hfffff, 5'd1, OPC_LUI}, 1);
    push_fetch({12'h7ff, 5'd1, 3'd6, 5'd2, OPC_IMM}, 1);
    push_fetch({12'hfff, 5'd0, 3'd0, 5'd3, OPC_IMM}, 1);
    push_fetch({6'h10, 6'd63, 5'd3, 3'd5, 5'd4, OPC_IMM}, 1);
    push_fetch({F7_MD, 5'd0, 5'd2, F3_DIV, 5'd5, OPC_OP}, 1);
    push_fetch({F7_MD, 5'd0, 5'd2, F3_REMU, 5'd6, OPC_OP}, 1);
    push_fetch({F7_BASE, 5'd3, 5'd3, 3'd1, 5'd7, OPC_OP}, 1);
    push_fetch({F7_MD, 5'd3, 5'd7, F3_DIV, 5'd8, OPC_OP}, 1);
    push_fetch({F7_MD, 5'd3, 5'd7, F3_REM, 5'd9, OPC_OP}, 1);
    push_fetch({F7_MD, 5'd2, 5'd3, F3_MUL, 5'd10, OPC_OP32}, 1);
    push_fetch({F7_MD, 5'd2, 5'd1, 3'd1, 5'd11, OPC_OP}, 1);
    push_fetch({F7_ALT, 5'd2, 5'd3, 3'd5, 5'd12, OPC_OP32}, 1);
    push_fetch({12'h0, 5'd0, 3'd3, 5'd13, OPC_LOAD}, 1);
    push_fetch({7'h0, 5'd3, 5'd0, 3'd3, 5'd8, OPC_STORE}, 1);
    push_fetch(32'h0, 0);
    push_fetch(WORD_ECALL, 1);
    push_fetch(WORD_EBREAK, 1);
    push_fetch(32'h0010_1073, 1);
    push_fetch({12'h0, 5'd0, 3'd1, 5'd0, OPC_FENCE}, 1);
    push_fetch({1'b0, 10'd1, 1'b0, 8'd0, 5'd1, OPC_JAL}, 1);
    push_fetch(32'h13, 1);
    wait_idle();

    cfg_write('1 << 2);
    push_random(200);
    wait_idle();
    cfg_write(64'h8000_0000_0000_0000);
    send_pct = 72;
    push_random(200);
    wait_idle();
    cfg_write(64'h0000_1000);
    send_pct = 0; stall_pct = 72;
    push_random(200);
    wait_idle();
    cfg_write('1);
    send_pct = 9; stall_pct = 9;
    push_random(100);
    wait_idle();
    cfg_write(64'h0);
    send_pct = 0; stall_pct = 0;
    hold_req = 1;
    push_random(150);
    wait_idle();
    hold_req = 0;
    done = 1;
    $display("run: %0d beats accepted, %0d results checked, five start_pc settings",
             n_beats, n_results);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/rvis_pkg.sv
hw/rtl/rvis_ram.sv
hw/rtl/rvis_front.sv
hw/rtl/rvis_muldiv.sv
hw/rtl/rvis_back.sv
hw/rtl/rv64im_instruction_step.sv
bench/tb_rv64im_instruction_step.sv
